// ----- rtl/bdq_pkg.sv -----
// Package for the bounded double-ended queue.
// Holds field widths, reset values and command codes shared by all modules.
// Depends on nothing.
package bdq_pkg;

	localparam int DATA_W        = 32;
	localparam int CAP_W         = 11;
	localparam int CMD_W         = 3;
	localparam int DEPTH_DEFAULT = 1024;

	localparam logic [CAP_W-1:0]  CAP_RESET   = 11'd1024;
	localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

	// Command codes carried by the command field.
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

endpackage

// ----- rtl/bdq_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// Used as the entry store of the deque. Depends on bdq_pkg for the default width.
module bdq_ram
	import bdq_pkg::*;
#(
	parameter int WIDTH = DATA_W,
	parameter int DEPTH = DEPTH_DEFAULT,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/bounded_double_ended_queue.sv -----
// Bounded double-ended queue: ring buffer in a synchronous RAM plus control.
// Depends on bdq_pkg and bdq_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command beat: a command
//   code and a 32-bit value. Push front, push back, pop front, pop back or
//   query. Unused codes act as a query.
//   Output channel (out_valid / out_stall) returns one result beat per
//   command: success, front and rear values after the command (all ones when
//   empty), and empty and full flags.
//   Configuration channel (cfg_valid / cfg_ready) writes the capacity; it is
//   always ready and should only be written while the queue is idle.
//   Capacities above DEPTH act as DEPTH.
// Timing:
//   A command is accepted and the RAM is written or read at that edge. In the
//   read step that follows, the result is registered once the output register
//   is free; no new command is taken until then. The read step is set by the
//   registered read of the entry RAM, needed when a pop exposes a new front
//   or rear entry. When out_stall holds a result, the next command is still
//   accepted and waits in its read step until the output register frees up.
// Reset:
//   arst_n empties the queue and sets the capacity to 1024. No clearing pass.
module bounded_double_ended_queue
	import bdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Configuration channel.
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CAP_W-1:0]         capacity,
	// Command channel.
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         command,
	input  logic signed [DATA_W-1:0] value,
	// Result channel.
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     success,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] rear_value,
	output logic                     is_empty,
	output logic                     is_full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > CAP_W) ? CW : CAP_W;
	localparam int SW = ((AW > CW) ? AW : CW) + 1;

	localparam logic [MW-1:0] DEPTH_M    = MW'(DEPTH);
	localparam logic [SW-1:0] DEPTH_S    = SW'(DEPTH);
	localparam logic [AW-1:0] LAST_INDEX = AW'(DEPTH - 1);

	typedef enum logic [1:0] {
		RD_NONE,
		RD_FRONT,
		RD_REAR
	} rd_sel_t;

	logic [CAP_W-1:0]  cap_q;
	logic [AW-1:0]     front_q;
	logic [CW-1:0]     count_q;
	logic [DATA_W-1:0] front_val_q;
	logic [DATA_W-1:0] rear_val_q;
	logic              busy_q;
	rd_sel_t           rd_sel_s1;
	logic              ok_s1;
	logic              out_valid_q;

	logic              in_accept;
	logic              done;
	logic [MW-1:0]     eff_cap;
	logic              full_now;
	logic              empty_now;
	logic [AW-1:0]     front_dec;
	logic [AW-1:0]     front_inc;
	logic [CW-1:0]     ring_off;
	logic [SW-1:0]     ring_sum;
	logic [AW-1:0]     ring_pos;
	logic              cmd_ok;
	logic [AW-1:0]     front_nxt;
	logic [CW-1:0]     count_nxt;
	rd_sel_t           rd_sel_nxt;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;
	logic [DATA_W-1:0] front_res;
	logic [DATA_W-1:0] rear_res;
	logic              res_empty;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy_q;
	assign in_accept = in_valid && !busy_q;
	assign done      = busy_q && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	// Effective capacity and occupancy flags of the current state.
	assign eff_cap   = (MW'(cap_q) > DEPTH_M) ? DEPTH_M : MW'(cap_q);
	assign full_now  = MW'(count_q) >= eff_cap;
	assign empty_now = (count_q == '0);

	// Ring index arithmetic.
	assign front_dec = (front_q == '0) ? LAST_INDEX : front_q - AW'(1);
	assign front_inc = (front_q == LAST_INDEX) ? '0 : front_q + AW'(1);
	assign ring_off  = (command == CMD_POP_BACK) ? count_q - CW'(2) : count_q;
	assign ring_sum  = SW'(front_q) + SW'(ring_off);
	assign ring_pos  = (ring_sum >= DEPTH_S) ? AW'(ring_sum - DEPTH_S) : AW'(ring_sum);

	// Command decode: next state, RAM access and which entry to read back.
	always_comb begin
		cmd_ok     = 1'b1;
		front_nxt  = front_q;
		count_nxt  = count_q;
		rd_sel_nxt = RD_NONE;
		ram_we     = 1'b0;
		ram_waddr  = ring_pos;
		ram_re     = 1'b0;
		ram_raddr  = ring_pos;
		unique case (command)
			CMD_PUSH_FRONT: begin
				cmd_ok    = !full_now;
				front_nxt = full_now ? front_q : front_dec;
				count_nxt = full_now ? count_q : count_q + CW'(1);
				ram_we    = in_accept && !full_now;
				ram_waddr = front_dec;
			end
			CMD_PUSH_BACK: begin
				cmd_ok    = !full_now;
				count_nxt = full_now ? count_q : count_q + CW'(1);
				ram_we    = in_accept && !full_now;
			end
			CMD_POP_FRONT: begin
				cmd_ok     = !empty_now;
				front_nxt  = empty_now ? front_q : front_inc;
				count_nxt  = empty_now ? count_q : count_q - CW'(1);
				rd_sel_nxt = empty_now ? RD_NONE : RD_FRONT;
				ram_re     = in_accept && !empty_now;
				ram_raddr  = front_inc;
			end
			CMD_POP_BACK: begin
				cmd_ok     = !empty_now;
				count_nxt  = empty_now ? count_q : count_q - CW'(1);
				rd_sel_nxt = empty_now ? RD_NONE : RD_REAR;
				ram_re     = in_accept && !empty_now;
			end
			CMD_QUERY: begin
				cmd_ok = 1'b1;
			end
			default: begin
				cmd_ok = 1'b1;
			end
		endcase
	end

	bdq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result of the command in its read step, with the freshly read entry.
	assign res_empty = (count_q == '0);
	assign front_res = (rd_sel_s1 == RD_FRONT) ? ram_rdata : front_val_q;
	assign rear_res  = (rd_sel_s1 == RD_REAR) ? ram_rdata : rear_val_q;

	// Control state: capacity, ring pointers, sequencing and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			front_q     <= '0;
			count_q     <= '0;
			busy_q      <= 1'b0;
			rd_sel_s1   <= RD_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= capacity;
			end
			if (in_accept) begin
				front_q   <= front_nxt;
				count_q   <= count_nxt;
				rd_sel_s1 <= rd_sel_nxt;
				busy_q    <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Cached end values: pushes set them at accept, pops from the RAM read.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			ok_s1 <= cmd_ok;
			if (cmd_ok && command == CMD_PUSH_FRONT) begin
				front_val_q <= value;
				if (empty_now) begin
					rear_val_q <= value;
				end
			end
			if (cmd_ok && command == CMD_PUSH_BACK) begin
				rear_val_q <= value;
				if (empty_now) begin
					front_val_q <= value;
				end
			end
		end else if (done) begin
			front_val_q <= front_res;
			rear_val_q  <= rear_res;
		end
	end

	// Output register for the result beat.
	always_ff @(posedge clk) begin
		if (done) begin
			success     <= ok_s1;
			front_value <= res_empty ? EMPTY_VALUE : front_res;
			rear_value  <= res_empty ? EMPTY_VALUE : rear_res;
			is_empty    <= res_empty;
			is_full     <= MW'(count_q) >= eff_cap;
		end
	end

	// The entry count never exceeds the store depth.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
		else $error("entry count exceeds store depth");

	// A shown empty result carries all-ones end values.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_empty) |-> (front_value == EMPTY_VALUE && rear_value == EMPTY_VALUE))
		else $error("empty result with live end values");

	// No command is taken while the previous one is still in its read cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("command accepted on back-to-back cycles");

	// A successful pop issues exactly one RAM read and never a write.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (!ram_we && in_accept))
		else $error("RAM read and write in the same command");

endmodule

// ----- bench/tb_bounded_double_ended_queue.sv -----
// Self-checking testbench for the bounded double-ended queue.
// Drives command beats and capacity writes, predicts every result beat and compares them.
// Depends on bdq_pkg and the bounded_double_ended_queue RTL.
module tb_bounded_double_ended_queue;
	import bdq_pkg::*;

	localparam int DEPTH          = DEPTH_DEFAULT;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 12;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef enum logic {KIND_CMD, KIND_CFG} beat_kind_t;

	// One pending beat for the driver: a command or a capacity write.
	typedef struct {
		beat_kind_t        kind;
		bit                drain;
		logic [CMD_W-1:0]  cmd;
		logic [DATA_W-1:0] val;
		logic [CAP_W-1:0]  cap;
	} pending_beat_t;

	typedef struct packed {
		logic              ok;
		logic [DATA_W-1:0] front;
		logic [DATA_W-1:0] rear;
		logic              empty;
		logic              full;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CAP_W-1:0]  capacity = CAP_RESET;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [CMD_W-1:0]  command = CMD_QUERY;
	logic [DATA_W-1:0] value = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              success;
	logic [DATA_W-1:0] front_value;
	logic [DATA_W-1:0] rear_value;
	logic              is_empty;
	logic              is_full;

	pending_beat_t pending_beats[$];
	deque_result_t expected_results[$];

	// Shadow copy of the deque.
	logic [DATA_W-1:0] shadow_store [DEPTH];
	int                shadow_head = 0;
	int                shadow_count = 0;
	logic [CAP_W-1:0]  shadow_cap = CAP_RESET;

	bit in_took = 1'b0;
	bit cfg_took = 1'b0;
	int error_count = 0;
	int idle_cycles = 0;
	int quiet_cycles = 0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int stall_tick = 0;

	bounded_double_ended_queue #(.DEPTH(DEPTH)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.capacity   (capacity),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.success    (success),
		.front_value(front_value),
		.rear_value (rear_value),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	// Clock with a period of 20.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one command to the shadow deque and work out its result beat.
	task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
			output deque_result_t res);
		int  limit;
		bit  was_full;
		bit  was_empty;
		limit = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
		was_full = shadow_count >= limit;
		was_empty = shadow_count == 0;
		res.ok = 1'b1;
		case (cmd)
			CMD_PUSH_FRONT: begin
				if (was_full) begin
					res.ok = 1'b0;
				end else begin
					shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
					shadow_store[shadow_head] = val;
					shadow_count++;
				end
			end
			CMD_PUSH_BACK: begin
				if (was_full) begin
					res.ok = 1'b0;
				end else begin
					shadow_store[(shadow_head + shadow_count) % DEPTH] = val;
					shadow_count++;
				end
			end
			CMD_POP_FRONT: begin
				if (was_empty) begin
					res.ok = 1'b0;
				end else begin
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_count--;
				end
			end
			CMD_POP_BACK: begin
				if (was_empty) begin
					res.ok = 1'b0;
				end else begin
					shadow_count--;
				end
			end
			default: begin
			end
		endcase
		res.empty = shadow_count == 0;
		res.full = shadow_count >= limit;
		if (res.empty) begin
			res.front = EMPTY_VALUE;
			res.rear = EMPTY_VALUE;
		end else begin
			res.front = shadow_store[shadow_head];
			res.rear = shadow_store[(shadow_head + shadow_count - 1) % DEPTH];
		end
	endtask

	task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Sample at the rising edge: track accepted beats, predict and check.
	always @(posedge clk) begin : monitor
		deque_result_t want;
		bit            out_took;
		if (arst_n) begin
			in_took = in_valid && !in_stall;
			cfg_took = cfg_valid && cfg_ready;
			out_took = out_valid && !out_stall;
			if (cfg_took) begin
				shadow_cap = capacity;
			end
			if (in_took) begin
				apply_command(command, value, want);
				expected_results.push_back(want);
			end
			if (out_took) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, got %h %h %h %b %b",
						$time, success, front_value, rear_value, is_empty, is_full);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("success", DATA_W'(want.ok), DATA_W'(success));
					compare_field("front_value", want.front, front_value);
					compare_field("rear_value", want.rear, rear_value);
					compare_field("is_empty", DATA_W'(want.empty), DATA_W'(is_empty));
					compare_field("is_full", DATA_W'(want.full), DATA_W'(is_full));
				end
			end
			// Quiet cycles let the block settle before a capacity write.
			if (expected_results.size() == 0 && !in_valid) begin
				quiet_cycles++;
			end else begin
				quiet_cycles = 0;
			end
			if (in_took || cfg_took || out_took) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Sender: issues pending beats at the falling edge in bursts with gaps.
	always @(negedge clk) begin : driver
		pending_beat_t head;
		logic          next_in;
		logic          next_cfg;
		if (arst_n) begin
			next_in = in_valid;
			next_cfg = cfg_valid;
			if (in_valid && in_took) begin
				head = pending_beats.pop_front();
				next_in = 1'b0;
			end
			if (cfg_valid && cfg_took) begin
				head = pending_beats.pop_front();
				next_cfg = 1'b0;
			end
			if (!next_in && !next_cfg && pending_beats.size() > 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					head = pending_beats[0];
					if (head.kind == KIND_CFG) begin
						if (expected_results.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
							next_cfg = 1'b1;
							capacity <= head.cap;
						end
					end else if (!head.drain || expected_results.size() == 0) begin
						next_in = 1'b1;
						command <= head.cmd;
						value <= head.val;
						if (burst_left > 1) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(1, 40);
							gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
						end
					end
				end
			end
			in_valid <= next_in;
			cfg_valid <= next_cfg;
		end
	end

	// Receiver: stall pattern that switches at random between four modes: none, random and two periodic ones.
	always @(negedge clk) begin : receiver
		if (stall_left == 0) begin
			stall_mode = $urandom_range(3);
			stall_left = $urandom_range(10, 60);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(2) == 0);
			2: out_stall <= (stall_tick % 5 < 3);
			default: out_stall <= (stall_left % 24 < 18);
		endcase
		stall_tick++;
	end

	task automatic add_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
			input bit drain);
		pending_beat_t b;
		b.kind = KIND_CMD;
		b.drain = drain;
		b.cmd = cmd;
		b.val = val;
		b.cap = '0;
		pending_beats.push_back(b);
	endtask

	task automatic add_capacity(input logic [CAP_W-1:0] cap);
		pending_beat_t b;
		b.kind = KIND_CFG;
		b.drain = 1'b1;
		b.cmd = CMD_QUERY;
		b.val = '0;
		b.cap = cap;
		pending_beats.push_back(b);
	endtask

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(11))
			0: return 32'h0000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// A capacity write followed by a random mix of commands.
	task automatic add_random_phase(input logic [CAP_W-1:0] cap, input int count,
			input int push_pct);
		int               r;
		logic [CMD_W-1:0] cmd;
		add_capacity(cap);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < push_pct) begin
				cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
			end else if (r < push_pct + (100 - push_pct) * 85 / 100) begin
				cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
			end else begin
				cmd = CMD_W'($urandom_range(4, 7));
			end
			add_command(cmd, pick_value(), $urandom_range(59) == 0);
		end
	endtask

	initial begin
		// Directed part at the reset capacity: empty queue, extremes, wrap of the front.
		add_command(CMD_QUERY, 32'h1234_5678, 1'b0);
		add_command(CMD_POP_FRONT, 32'h0000_0000, 1'b0);
		add_command(CMD_POP_BACK, 32'hffff_ffff, 1'b0);
		add_command(CMD_PUSH_FRONT, 32'h7fff_ffff, 1'b0);
		add_command(CMD_PUSH_BACK, 32'h8000_0000, 1'b0);
		add_command(CMD_PUSH_FRONT, 32'h0000_0000, 1'b0);
		add_command(CMD_PUSH_BACK, 32'hffff_ffff, 1'b0);
		add_command(CMD_W'(5), $urandom, 1'b0);
		add_command(CMD_W'(6), $urandom, 1'b0);
		add_command(CMD_W'(7), $urandom, 1'b0);
		add_command(CMD_POP_FRONT, $urandom, 1'b0);
		add_command(CMD_POP_FRONT, $urandom, 1'b0);
		add_command(CMD_POP_BACK, $urandom, 1'b0);
		add_command(CMD_POP_BACK, $urandom, 1'b1);
		// Capacity of one: the second push fails.
		add_capacity(11'd1);
		add_command(CMD_PUSH_BACK, 32'haaaa_5555, 1'b0);
		add_command(CMD_PUSH_FRONT, 32'h1111_2222, 1'b0);
		add_command(CMD_POP_FRONT, $urandom, 1'b0);
		add_command(CMD_PUSH_FRONT, 32'h5555_aaaa, 1'b0);
		add_command(CMD_POP_BACK, $urandom, 1'b0);
		// Capacity of zero: always full, every push fails.
		add_capacity(11'd0);
		add_command(CMD_PUSH_FRONT, $urandom, 1'b0);
		add_command(CMD_PUSH_BACK, $urandom, 1'b0);
		// Capacity of three filled by three pushes, then lowered below the count: entries kept, the push fails.
		add_capacity(11'd3);
		add_command(CMD_PUSH_BACK, $urandom, 1'b0);
		add_command(CMD_PUSH_BACK, $urandom, 1'b0);
		add_command(CMD_PUSH_FRONT, $urandom, 1'b0);
		add_capacity(11'd1);
		add_command(CMD_PUSH_FRONT, $urandom, 1'b0);
		add_command(CMD_POP_BACK, $urandom, 1'b0);
		add_command(CMD_QUERY, $urandom, 1'b0);

		// Random phases; the saturated one grows the ring to several hundred entries.
		add_random_phase(11'd5, 120, 55);
		add_random_phase(11'd1, 40, 50);
		add_random_phase(11'd0, 20, 60);
		add_random_phase(11'd2047, 600, 98);
		add_random_phase(11'd4, 40, 40);
		add_random_phase(11'd1024, 100, 45);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_beats.size() != 0 || expected_results.size() != 0 || in_valid || cfg_valid)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
